// ===== rtl/core/e2cd_pkg.sv =====
package e2cd_pkg;

	// pipeline depth, one register stage per entry
	localparam int STAGES = 13;

	// field widths
	localparam int SECS_W  = 48;
	localparam int YEAR_W  = 24;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int WDAY_W  = 3;

	// calendar constants
	localparam longint unsigned SECS_PER_DAY    = 64'd86400;
	localparam longint unsigned SHIFT_TO_MARCH0 = 64'd719468;
	localparam longint unsigned DAYS_PER_ERA    = 64'd146097;
	localparam longint unsigned DAYS_PER_4Y     = 64'd1460;
	localparam longint unsigned DAYS_PER_CENT   = 64'd36524;
	localparam longint unsigned DAYS_PER_YEAR   = 64'd365;

	// bias that makes the seconds count nonnegative; a whole number of
	// eras and weeks, so era index, day of era and weekday keep their phase
	localparam longint unsigned BIAS_DAY_UNIT = DAYS_PER_ERA * 64'd7;
	localparam longint unsigned BIAS_SEC_UNIT = BIAS_DAY_UNIT * SECS_PER_DAY;
	localparam longint unsigned BIAS_UNITS    =
		((64'd1 << (SECS_W - 1)) + BIAS_SEC_UNIT - 64'd1) / BIAS_SEC_UNIT;
	localparam longint unsigned BIAS_DAYS     = BIAS_UNITS * BIAS_DAY_UNIT;
	localparam logic [SECS_W:0] SEC_BIAS      = (SECS_W + 1)'(BIAS_DAYS * SECS_PER_DAY);
	localparam logic [YEAR_W-1:0] YEAR_BIAS   = YEAR_W'(BIAS_UNITS * 64'd7 * 64'd400);

	// seconds / 86400 = (seconds >> 7) / 675, done as two digits of 21 bits
	localparam int               SHR_DAY  = 7;
	localparam longint unsigned  DIV_DAY  = SECS_PER_DAY >> SHR_DAY;
	localparam int T_W    = SECS_W + 1 - SHR_DAY;
	localparam int TL_W   = 21;
	localparam int TH_W   = T_W - TL_W;
	localparam int REM_W  = 10;
	localparam int QH_W   = 12;
	localparam int V_W    = REM_W + TL_W;

	// reciprocals, exact for every operand below 2^n with shift n + clog2(d)
	localparam int  MH_SH = TH_W + 10;
	localparam int  MH_W  = 22;
	localparam logic [MH_W-1:0] MH_MUL =
		MH_W'(((64'd1 << MH_SH) + DIV_DAY - 64'd1) / DIV_DAY);
	localparam int  PH_W  = TH_W + MH_W;

	localparam int  ML_SH = V_W + 10;
	localparam int  ML_W  = 32;
	localparam logic [ML_W-1:0] ML_MUL =
		ML_W'(((64'd1 << ML_SH) + DIV_DAY - 64'd1) / DIV_DAY);
	localparam int  PL_W  = V_W + ML_W;

	localparam int  DAYS_W = 32;
	localparam int  ERA_SH = DAYS_W + 18;
	localparam int  ERA_MW = 33;
	localparam logic [ERA_MW-1:0] ERA_MUL =
		ERA_MW'(((64'd1 << ERA_SH) + DAYS_PER_ERA - 64'd1) / DAYS_PER_ERA);
	localparam int  PE_W   = DAYS_W + ERA_MW;
	localparam int  ERA_W  = 15;
	localparam int  DOE_W  = 18;

	localparam int  A_SH  = DOE_W + 11;
	localparam int  A_MW  = 19;
	localparam logic [A_MW-1:0] A_MUL =
		A_MW'(((64'd1 << A_SH) + DAYS_PER_4Y - 64'd1) / DAYS_PER_4Y);
	localparam int  PA_W  = DOE_W + A_MW;

	localparam int  Y_SH  = DOE_W + 9;
	localparam int  Y_MW  = 19;
	localparam logic [Y_MW-1:0] Y_MUL =
		Y_MW'(((64'd1 << Y_SH) + DAYS_PER_YEAR - 64'd1) / DAYS_PER_YEAR);
	localparam int  PY_W  = DOE_W + Y_MW;

	localparam int  YOE_W = 9;
	localparam int  DOY_W = 9;
	localparam int  MP_W  = 4;

	// first day of each March-based month within the year
	localparam logic [DOY_W-1:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};
	localparam logic [MP_W-1:0] MP_JAN = 4'd10;

	// sum of octal digits, congruent to x modulo 7
	function automatic logic [6:0] oct_sum(input logic [DAYS_W-1:0] x);
		logic [32:0] xp;
		logic [6:0]  s;
		xp = {1'b0, x};
		s  = '0;
		for (int i = 0; i < 11; i++) begin
			s = s + 7'(xp[3*i +: 3]);
		end
		return s;
	endfunction

	// weekday from an octal digit sum of the biased day count
	function automatic logic [WDAY_W-1:0] wday_fold(input logic [6:0] s);
		logic [3:0] s2;
		logic [3:0] s3;
		logic [2:0] r;
		s2 = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
		s3 = 4'(s2[2:0]) + 4'(s2[3]);
		r  = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
		return (r >= 3'd3) ? 3'(r - 3'd3) : 3'(r + 3'd4);
	endfunction

endpackage

// ===== rtl/core/epoch_seconds_to_civil_date_top.sv =====
// Converts signed epoch seconds to a proleptic Gregorian date and weekday
// (0 is Sunday). One transfer is taken every cycle while in_ready is high;
// the result passes through the thirteen register stages of the pipeline,
// the first of which loads at the input transfer (the stage count is held
// by the chain of constant-reciprocal multipliers: days from seconds in two
// digits, era, years of era). Each stage holds its item while the next one
// is full, so a stalled output backs up stage by stage and empty stages keep
// filling; in_ready drops only when all stages hold an item. The block keeps
// no state between items.
module epoch_seconds_to_civil_date_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [e2cd_pkg::SECS_W-1:0]  unix_seconds,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [e2cd_pkg::YEAR_W-1:0]  year,
	output logic [e2cd_pkg::MONTH_W-1:0]        month,
	output logic [e2cd_pkg::DOM_W-1:0]          day_of_month,
	output logic [e2cd_pkg::WDAY_W-1:0]         weekday
);
	import e2cd_pkg::*;

	// stage valid bits and load enables
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[STAGES-1];

	// s1: bias to nonnegative seconds, drop the power-of-two part of 86400
	logic [SECS_W:0] sec_b;
	logic [T_W-1:0]  t_s1;

	assign sec_b = {unix_seconds[SECS_W-1], unix_seconds} + SEC_BIAS;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1 <= sec_b[SECS_W:SHR_DAY];
		end
	end

	// s2: high digit times reciprocal of 675
	logic [TH_W-1:0] th_s2;
	logic [TL_W-1:0] tl_s2;
	logic [PH_W-1:0] prodh_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			th_s2    <= t_s1[T_W-1:TL_W];
			tl_s2    <= t_s1[TL_W-1:0];
			prodh_s2 <= PH_W'(t_s1[T_W-1:TL_W]) * PH_W'(MH_MUL);
		end
	end

	// s3: high quotient and remainder, remainder joins the low digit
	logic [QH_W-1:0] qh;
	logic [TH_W-1:0] rh;
	logic [QH_W-1:0] qh_s3;
	logic [V_W-1:0]  v_s3;

	assign qh = prodh_s2[PH_W-1:MH_SH];
	assign rh = th_s2 - TH_W'(qh) * TH_W'(DIV_DAY);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qh_s3 <= qh;
			v_s3  <= {rh[REM_W-1:0], tl_s2};
		end
	end

	// s4: low digit times reciprocal of 675
	logic [QH_W-1:0] qh_s4;
	logic [PL_W-1:0] prodl_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			qh_s4    <= qh_s3;
			prodl_s4 <= PL_W'(v_s3) * PL_W'(ML_MUL);
		end
	end

	// s5: biased day count, shift to a March-based epoch, weekday digit sum
	logic [DAYS_W-1:0] days_b;
	logic [DAYS_W-1:0] z_s5;
	logic [6:0]        wsum_s5;

	assign days_b = {qh_s4[DAYS_W-TL_W-1:0], prodl_s4[ML_SH +: TL_W]};

	always_ff @(posedge clk) begin
		if (en[4]) begin
			z_s5    <= days_b + DAYS_W'(SHIFT_TO_MARCH0);
			wsum_s5 <= oct_sum(days_b);
		end
	end

	// s6: era by reciprocal, weekday finished
	logic [DAYS_W-1:0] z_s6;
	logic [PE_W-1:0]   prode_s6;
	logic [WDAY_W-1:0] wd_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			z_s6     <= z_s5;
			prode_s6 <= PE_W'(z_s5) * PE_W'(ERA_MUL);
			wd_s6    <= wday_fold(wsum_s5);
		end
	end

	// s7: era index and day of era
	logic [ERA_W-1:0]  era;
	logic [DAYS_W-1:0] doe_full;
	logic [ERA_W-1:0]  era_s7;
	logic [DOE_W-1:0]  doe_s7;
	logic [WDAY_W-1:0] wd_s7;

	assign era      = prode_s6[PE_W-1:ERA_SH];
	assign doe_full = z_s6 - DAYS_W'(era) * DAYS_W'(DAYS_PER_ERA);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			era_s7 <= era;
			doe_s7 <= doe_full[DOE_W-1:0];
			wd_s7  <= wd_s6;
		end
	end

	// s8: four-year count by reciprocal, century counts by compare
	logic [ERA_W-1:0]  era_s8;
	logic [DOE_W-1:0]  doe_s8;
	logic [PA_W-1:0]   pa_s8;
	logic [2:0]        cent_s8;
	logic              last_s8;
	logic [WDAY_W-1:0] wd_s8;
	logic [2:0]        cent;

	always_comb begin
		cent = '0;
		for (int k = 1; k <= 4; k++) begin
			cent = cent + 3'(doe_s7 >= DOE_W'(DAYS_PER_CENT * 64'(k)));
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			era_s8  <= era_s7;
			doe_s8  <= doe_s7;
			pa_s8   <= PA_W'(doe_s7) * PA_W'(A_MUL);
			cent_s8 <= cent;
			last_s8 <= (doe_s7 == DOE_W'(DAYS_PER_ERA - 64'd1));
			wd_s8   <= wd_s7;
		end
	end

	// s9: day of era with leap days taken out
	logic [ERA_W-1:0]  era_s9;
	logic [DOE_W-1:0]  doe_s9;
	logic [DOE_W-1:0]  n_s9;
	logic [WDAY_W-1:0] wd_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			era_s9 <= era_s8;
			doe_s9 <= doe_s8;
			n_s9   <= doe_s8 - DOE_W'(pa_s8[PA_W-1:A_SH]) + DOE_W'(cent_s8)
				- DOE_W'(last_s8);
			wd_s9  <= wd_s8;
		end
	end

	// s10: year of era by reciprocal of 365
	logic [ERA_W-1:0]  era_s10;
	logic [DOE_W-1:0]  doe_s10;
	logic [PY_W-1:0]   py_s10;
	logic [WDAY_W-1:0] wd_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			era_s10 <= era_s9;
			doe_s10 <= doe_s9;
			py_s10  <= PY_W'(n_s9) * PY_W'(Y_MUL);
			wd_s10  <= wd_s9;
		end
	end

	// s11: day of year
	logic [YOE_W-1:0]  yoe;
	logic [1:0]        ycent;
	logic [DOE_W-1:0]  ystart;
	logic [DOE_W-1:0]  doy_full;
	logic [ERA_W-1:0]  era_s11;
	logic [YOE_W-1:0]  yoe_s11;
	logic [DOY_W-1:0]  doy_s11;
	logic [WDAY_W-1:0] wd_s11;

	assign yoe      = py_s10[Y_SH +: YOE_W];
	assign ycent    = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
	assign ystart   = DOE_W'(yoe) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe[YOE_W-1:2])
		- DOE_W'(ycent);
	assign doy_full = doe_s10 - ystart;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			era_s11 <= era_s10;
			yoe_s11 <= yoe;
			doy_s11 <= doy_full[DOY_W-1:0];
			wd_s11  <= wd_s10;
		end
	end

	// s12: March-based month index, unadjusted year
	logic [MP_W-1:0]        mp;
	logic [YEAR_W-1:0]      ybase_s12;
	logic [MP_W-1:0]        mp_s12;
	logic [DOY_W-1:0]       doy_s12;
	logic [WDAY_W-1:0]      wd_s12;

	always_comb begin
		mp = '0;
		for (int k = 1; k < 12; k++) begin
			mp = mp + MP_W'(doy_s11 >= MONTH_START[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			ybase_s12 <= YEAR_W'(yoe_s11) + YEAR_W'(era_s11) * YEAR_W'(400) - YEAR_BIAS;
			mp_s12    <= mp;
			doy_s12   <= doy_s11;
			wd_s12    <= wd_s11;
		end
	end

	// s13: output register, January and February belong to the next year
	logic              jan_feb;
	logic [DOY_W-1:0]  dom_full;
	logic [YEAR_W-1:0] year_s13;
	logic [MONTH_W-1:0] month_s13;
	logic [DOM_W-1:0]  dom_s13;
	logic [WDAY_W-1:0] wd_s13;

	assign jan_feb  = (mp_s12 >= MP_JAN);
	assign dom_full = doy_s12 - MONTH_START[mp_s12] + 9'd1;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			year_s13  <= ybase_s12 + YEAR_W'(jan_feb);
			month_s13 <= jan_feb ? MONTH_W'(mp_s12 - MP_JAN + 4'd1)
				: MONTH_W'(mp_s12 + 4'd3);
			dom_s13   <= dom_full[DOM_W-1:0];
			wd_s13    <= wd_s12;
		end
	end

	assign year         = year_s13;
	assign month        = month_s13;
	assign day_of_month = dom_s13;
	assign weekday      = wd_s13;

`ifndef SYNTHESIS
	// ready drops only with every stage full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_q == {STAGES{1'b1}}))
		else $error("input stalled while a stage is empty");

	// an accepted transfer lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transfer lost at pipeline entry");

	// result fields stay in their calendar ranges
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0))
		else $error("month or day out of range");

	a_wday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weekday != 3'd7))
		else $error("weekday out of range");
`endif

endmodule

// ===== dv/civil_date_checker.sv =====
`timescale 1ns / 1ps

module civil_date_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [e2cd_pkg::SECS_W-1:0]  unix_seconds,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [e2cd_pkg::YEAR_W-1:0]  year,
	input  logic [e2cd_pkg::MONTH_W-1:0]        month,
	input  logic [e2cd_pkg::DOM_W-1:0]          day_of_month,
	input  logic [e2cd_pkg::WDAY_W-1:0]         weekday,
	output int                                  mismatches,
	output int                                  outstanding
);
	import e2cd_pkg::*;

	// signed copies of the calendar constants
	localparam longint DAY_SECS   = 86400;
	localparam longint MARCH0_OFS = 719468;
	localparam longint ERA_DAYS   = 146097;

	typedef struct {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DOM_W-1:0]         dom;
		logic [WDAY_W-1:0]        wday;
	} civil_date_t;

	civil_date_t pending_dates [$];
	int fail_total    = 0;
	int pending_total = 0;

	assign mismatches  = fail_total;
	assign outstanding = pending_total;

	// quotient rounded toward minus infinity
	function automatic longint floored_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// date and weekday of a second count, via march-based 400-year eras
	function automatic civil_date_t civil_date_of(input logic signed [SECS_W-1:0] secs);
		longint days, shifted, era, doe, yoe, doy, mp, d, m, y, wd;
		civil_date_t r;
		days    = floored_quot(longint'(secs), DAY_SECS);
		shifted = days + MARCH0_OFS;
		era     = floored_quot(shifted, ERA_DAYS);
		doe     = shifted - era * ERA_DAYS;
		yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp      = (5 * doy + 2) / 153;
		d       = doy - (153 * mp + 2) / 5 + 1;
		m       = (mp < 10) ? mp + 3 : mp - 9;
		y       = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		// 1970-01-01 was a thursday
		wd      = (days + 4) - floored_quot(days + 4, 7) * 7;
		r.year  = y[YEAR_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.dom   = d[DOM_W-1:0];
		r.wday  = wd[WDAY_W-1:0];
		return r;
	endfunction

	// compare each result transfer, then queue the prediction for each input transfer
	always @(posedge clk) begin
		civil_date_t want;
		int errs;
		errs = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_dates.size() == 0) begin
					$error("result transfer with no date pending: year %0d", year);
					errs++;
				end else begin
					want = pending_dates.pop_front();
					if (year !== want.year) begin
						$error("year: expected %0d, got %0d", want.year, year);
						errs++;
					end
					if (month !== want.month) begin
						$error("month: expected %0d, got %0d", want.month, month);
						errs++;
					end
					if (day_of_month !== want.dom) begin
						$error("day_of_month: expected %0d, got %0d", want.dom, day_of_month);
						errs++;
					end
					if (weekday !== want.wday) begin
						$error("weekday: expected %0d, got %0d", want.wday, weekday);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				pending_dates.push_back(civil_date_of(unix_seconds));
			end
		end
		fail_total    <= fail_total + errs;
		pending_total <= pending_dates.size();
	end

endmodule

// ===== dv/epoch_seconds_to_civil_date_top_tb.sv =====
`timescale 1ns / 1ps

module epoch_seconds_to_civil_date_top_tb;
	import e2cd_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 450;
	localparam int PHASE_ITEMS  = 90;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic signed [SECS_W-1:0]  unix_seconds  = '0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic signed [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0]        month;
	logic [DOM_W-1:0]          day_of_month;
	logic [WDAY_W-1:0]         weekday;
	int                        mismatches;
	int                        outstanding;

	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	epoch_seconds_to_civil_date_top u_dut (.*);

	civil_date_checker u_checker (.*);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each transfer
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one input transfer after a random gap
	task automatic send_seconds(input longint secs);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		unix_seconds <= SECS_W'(secs);
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		// zero, day edges, year end, leap days, era starts, range ends, bit patterns
		longint directed_secs [$] = '{
			0, -1, 1, 86399, 86400, -86400, -86401,
			946684799, 946684800, 951782400, 951868800,
			-2203977600, 4107542400,
			-62162035200, -62162035201, -49539254400, -49539254401,
			140737488355327, -140737488355328,
			93824992236885, -93824992236886
		};
		longint secs, days, era_idx;
		int kind, phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_secs[i]) begin
			send_seconds(directed_secs[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			phase = i / PHASE_ITEMS;
			// phases: both sides busy, back pressure, slow sender, then random on both
			tx_calm = (phase == 0 || phase == 1);
			rx_calm <= (phase == 0 || phase == 2);

			// let the pipeline run empty once before the last phases
			if (i == 3 * PHASE_ITEMS) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end

			kind = $urandom_range(0, 9);
			case (kind) inside
				[0:2]: begin
					secs = longint'(SECS_W'({16'($urandom()), 32'($urandom())}));
					secs = (secs << 16) >>> 16;
				end
				[3:4]: begin
					secs = longint'(int'($urandom())) * 4;
				end
				[5:6]: begin
					days = longint'(int'($urandom())) >>> 1;
					secs = days * 86400 + longint'($urandom_range(0, 2)) - 1;
				end
				[7:8]: begin
					// around the start of a 400-year era
					era_idx = longint'($urandom_range(0, 22000)) - 11000;
					days = era_idx * 146097 - 719468 + longint'($urandom_range(0, 800)) - 400;
					secs = days * 86400 + longint'($urandom_range(0, 86399));
				end
				default: begin
					if ($urandom_range(0, 1) == 1) begin
						secs = 140737488355327 - longint'($urandom_range(0, 1000000));
					end else begin
						secs = -140737488355328 + longint'($urandom_range(0, 1000000));
					end
				end
			endcase
			send_seconds(secs);
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2 * STAGES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
